### rtl/sparse_clustered_bitset_macros.svh
// Assertion macros used by the bitset RTL file.
`ifndef SPARSE_CLUSTERED_BITSET_MACROS_SVH
`define SPARSE_CLUSTERED_BITSET_MACROS_SVH

// An implication checked at every rising clock edge outside reset.
`define SCB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequence is checked in the cycle after the antecedent.
`define SCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/scb_pkg.sv
`default_nettype none
package scb_pkg;
  localparam int MaxClusters     = 16;
  localparam int WordsPerCluster = 16;
  localparam int WordWidth       = 32;
  localparam int SlotW  = (MaxClusters > 1) ? $clog2(MaxClusters) : 1;
  localparam int CntW   = $clog2(MaxClusters + 1);
  localparam int WselW  = 4;
  localparam int AddrW  = SlotW + WselW;
  localparam int KeyW   = 23;
  localparam int EcntW  = 14;

  localparam logic [2:0] CmdAdd    = 3'd0;
  localparam logic [2:0] CmdRemove = 3'd1;
  localparam logic [2:0] CmdTest   = 3'd2;
  localparam logic [2:0] CmdFind   = 3'd3;
  localparam logic [2:0] CmdClear  = 3'd4;

  // Index of the lowest set bit; zero for an empty word.
  function automatic logic [4:0] lowest_bit(input logic [WordWidth-1:0] w);
    logic [4:0] n;
    n = 5'd0;
    for (int i = WordWidth - 1; i >= 0; i--) begin
      if (w[i]) n = 5'(i);
    end
    return n;
  endfunction
endpackage
`default_nettype wire

### rtl/scb_ram.sv
`default_nettype none
module scb_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/sparse_clustered_bitset.sv
// Channel   Dir  tdata (low bit up)                         tuser
// s_axis    in   value[31:0]                                command[2:0]
// m_axis    out  found_value[31:0], element_count[45:32]    hit[0], status[1]
//
// One item at a time; s_axis_tready stays low until the result has been taken.
// Test, remove and add of a present key: a search over the slots in key order (up to 16),
// then the read, wait, update and done states, after which m_axis_tvalid rises.
// An add that allocates also moves each higher cluster up a slot, word by word through a
// read state and a write state, and zeroes the new cluster's 16 words, one a cycle.
// Find next checks slots in key order and reads each cluster scanned word by word.
// Reset is synchronous; the result holds until m_axis_tready.
`default_nettype none
`include "sparse_clustered_bitset_macros.svh"
module sparse_clustered_bitset (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // value
  input  wire logic [2:0]  s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // found_value, element_count, zero fill
  output logic [1:0]       m_axis_tuser   // hit, status
);
  localparam logic [3:0] StIdle = 4'd0, StSearch = 4'd1, StRead = 4'd2,
    StWait = 4'd3, StBit = 4'd4, StShiftRd = 4'd5, StShiftWr = 4'd6,
    StZero = 4'd7, StFindRd = 4'd8, StFindChk = 4'd9, StDone = 4'd10;

  logic [3:0] state;
  logic [2:0] cmd;
  logic [31:0] value;
  logic [scb_pkg::KeyW-1:0] keys [scb_pkg::MaxClusters];
  logic [scb_pkg::CntW-1:0] ccount;
  logic [scb_pkg::EcntW-1:0] ecount;
  logic [scb_pkg::CntW-1:0] idx;       // slot scan / shift position
  logic [scb_pkg::SlotW-1:0] slot;
  logic [scb_pkg::WselW-1:0] word;
  logic found_slot;
  logic hit, status;
  logic [31:0] found;

  logic we;
  logic [scb_pkg::AddrW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  scb_ram #(.Width(32), .Depth(scb_pkg::MaxClusters * scb_pkg::WordsPerCluster)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  wire [scb_pkg::KeyW-1:0] key = value[31:9];
  wire [scb_pkg::SlotW-1:0] islot = idx[scb_pkg::SlotW-1:0];
  wire [scb_pkg::KeyW-1:0] ikey = keys[islot];
  wire [31:0] bitm = 32'd1 << value[4:0];
  // During a find scan rdata holds the word one below the current word index.
  wire [31:0] fmask = (ikey == key && (word - 1'b1) == value[8:5]) ?
                      (32'hFFFFFFFF << value[4:0]) : 32'hFFFFFFFF;

  assign s_axis_tready = (state == StIdle) && !m_axis_tvalid;

  always_comb begin
    we = 1'b0;
    waddr = {slot, word};
    wdata = rdata;
    raddr = {slot, word};
    case (state)
      StShiftRd: raddr = {islot - 1'b1, word};
      StShiftWr: begin we = 1'b1; waddr = {islot, word}; end
      StZero:    begin we = 1'b1; wdata = '0; end
      StFindRd:  raddr = {islot, word};
      StBit: begin
        we = (cmd == scb_pkg::CmdAdd) ? ((rdata & bitm) == 0) :
             (cmd == scb_pkg::CmdRemove) ? ((rdata & bitm) != 0) : 1'b0;
        wdata = (cmd == scb_pkg::CmdAdd) ? (rdata | bitm) : (rdata & ~bitm);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      ccount <= '0;
      ecount <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        StIdle: if (s_axis_tvalid && s_axis_tready) begin
          cmd <= s_axis_tuser;
          value <= s_axis_tdata;
          idx <= '0;
          hit <= 1'b0;
          status <= 1'b0;
          found <= '0;
          found_slot <= 1'b0;
          word <= '0;
          case (s_axis_tuser)
            scb_pkg::CmdAdd, scb_pkg::CmdRemove, scb_pkg::CmdTest:
              state <= StSearch;
            scb_pkg::CmdFind: state <= StFindChk;
            scb_pkg::CmdClear: begin
              ccount <= '0;
              ecount <= '0;
              state <= StDone;
            end
            default: state <= StDone;
          endcase
        end
        StSearch: begin
          // Walk slots in key order; stop at the key or the first larger key.
          if (idx == ccount || ikey > key) begin
            if (cmd != scb_pkg::CmdAdd) state <= StDone;
            else if (ccount == scb_pkg::CntW'(scb_pkg::MaxClusters)) begin
              status <= 1'b1;
              state <= StDone;
            end else begin
              slot <= islot;
              idx <= ccount;
              word <= '0;
              state <= (idx == ccount) ? StZero : StShiftRd;
            end
          end else if (ikey == key) begin
            slot <= islot;
            word <= value[8:5];
            state <= StRead;
          end else idx <= idx + 1'b1;
        end
        StShiftRd: state <= StShiftWr;
        StShiftWr: begin
          word <= word + 1'b1;
          state <= StShiftRd;
          if (word == '1) begin
            keys[islot] <= keys[islot - 1'b1];
            idx <= idx - 1'b1;
            if (islot - 1'b1 == slot) state <= StZero;
          end
        end
        StZero: begin
          word <= word + 1'b1;
          if (word == '1) begin
            keys[slot] <= key;
            ccount <= ccount + 1'b1;
            state <= StRead;
          end
        end
        StRead: begin
          word <= value[8:5];
          state <= StWait;
        end
        StWait: state <= StBit;
        StBit: begin
          if (cmd == scb_pkg::CmdAdd && (rdata & bitm) == 0) begin
            hit <= 1'b1;
            ecount <= ecount + 1'b1;
          end else if (cmd == scb_pkg::CmdRemove && (rdata & bitm) != 0) begin
            hit <= 1'b1;
            ecount <= ecount - 1'b1;
          end else if (cmd == scb_pkg::CmdTest && (rdata & bitm) != 0) hit <= 1'b1;
          state <= StDone;
        end
        StFindChk: begin
          // Skip slots below the start key; start word only in the start cluster.
          if (idx == ccount) state <= StDone;
          else if (ikey < key) idx <= idx + 1'b1;
          else begin
            word <= (ikey == key) ? value[8:5] : '0;
            state <= StFindRd;
          end
        end
        StFindRd: begin
          if (found_slot) begin
            if ((rdata & fmask) != 0) begin
              hit <= 1'b1;
              found <= {ikey, word - 1'b1, scb_pkg::lowest_bit(rdata & fmask)};
              state <= StDone;
            end else if (word == '0) begin
              found_slot <= 1'b0;
              idx <= idx + 1'b1;
              state <= StFindChk;
            end else word <= word + 1'b1;
          end else begin
            found_slot <= 1'b1;
            word <= word + 1'b1;
          end
        end
        StDone: begin
          m_axis_tvalid <= 1'b1;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, ecount, found};
  assign m_axis_tuser = {status, hit};

  `SCB_ASSERT_IMP(a_count_range, clk, rst, 1'b1, ccount <= scb_pkg::CntW'(scb_pkg::MaxClusters), "cluster count overflow")
  `SCB_ASSERT_IMP(a_ready_idle, clk, rst, s_axis_tready, state == StIdle, "ready outside idle")
  `SCB_ASSERT_NEXT(a_done_valid, clk, rst, state == StDone, m_axis_tvalid, "result lost")
endmodule
`default_nettype wire

### tb/tb_sparse_clustered_bitset.sv
`timescale 1ns / 1ps
module tb_sparse_clustered_bitset;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
  } op_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] found;
    logic        status;
    logic [13:0] count;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  sparse_clustered_bitset DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #6 clk = ~clk;

  // Shadow of the set contents, clusters kept in ascending key order.
  logic [scb_pkg::KeyW-1:0]      shadow_key [scb_pkg::MaxClusters];
  logic [scb_pkg::WordWidth-1:0] shadow_bits [scb_pkg::MaxClusters][scb_pkg::WordsPerCluster];
  int                            shadow_clusters = 0;
  logic [13:0]                   shadow_count = '0;

  op_t  pending_ops [$];
  res_t expected_results [$];
  int   mismatches = 0;
  bit   stimulus_done = 1'b0;
  int   hold_cycles = 0;

  function automatic int find_slot(input logic [scb_pkg::KeyW-1:0] key);
    for (int i = 0; i < shadow_clusters; i++)
      if (shadow_key[i] == key) return i;
    return -1;
  endfunction

  function automatic res_t apply_op(input op_t op);
    res_t r;
    logic [scb_pkg::KeyW-1:0] key;
    logic [3:0] wsel;
    logic [31:0] mask, bits;
    int slot, pos;
    r = '0;
    key = op.value[31:9];
    wsel = op.value[8:5];
    mask = 32'd1 << op.value[4:0];
    case (op.cmd)
      scb_pkg::CmdAdd: begin
        slot = find_slot(key);
        if (slot < 0 && shadow_clusters >= scb_pkg::MaxClusters) begin
          r.status = 1'b1;
        end else begin
          if (slot < 0) begin
            pos = shadow_clusters;
            while (pos > 0 && shadow_key[pos-1] > key) begin
              shadow_key[pos] = shadow_key[pos-1];
              shadow_bits[pos] = shadow_bits[pos-1];
              pos--;
            end
            shadow_key[pos] = key;
            for (int w = 0; w < scb_pkg::WordsPerCluster; w++) shadow_bits[pos][w] = '0;
            shadow_clusters++;
            slot = pos;
          end
          if ((shadow_bits[slot][wsel] & mask) == 0) begin
            shadow_bits[slot][wsel] |= mask;
            shadow_count++;
            r.hit = 1'b1;
          end
        end
      end
      scb_pkg::CmdRemove: begin
        slot = find_slot(key);
        if (slot >= 0 && (shadow_bits[slot][wsel] & mask) != 0) begin
          shadow_bits[slot][wsel] &= ~mask;
          shadow_count--;
          r.hit = 1'b1;
        end
      end
      scb_pkg::CmdTest: begin
        slot = find_slot(key);
        if (slot >= 0 && (shadow_bits[slot][wsel] & mask) != 0) r.hit = 1'b1;
      end
      scb_pkg::CmdFind: begin
        for (int i = 0; i < shadow_clusters && !r.hit; i++) begin
          if (shadow_key[i] >= key) begin
            for (int w = 0; w < scb_pkg::WordsPerCluster && !r.hit; w++) begin
              bits = shadow_bits[i][w];
              if (shadow_key[i] == key) begin
                if (w < wsel) bits = '0;
                else if (w == wsel) bits &= 32'hFFFFFFFF << op.value[4:0];
              end
              if (bits != 0) begin
                r.hit = 1'b1;
                r.found = {shadow_key[i], 4'(w), 5'd0};
                for (int b = 31; b >= 0; b--) if (bits[b]) r.found[4:0] = 5'(b);
              end
            end
          end
        end
      end
      scb_pkg::CmdClear: begin
        shadow_clusters = 0;
        shadow_count = '0;
      end
      default: ;
    endcase
    r.count = shadow_count;
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // Driver: offers queued items with random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_op(op_t'({s_axis_tuser, s_axis_tdata})));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op_t op;
          op = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= op.cmd;
          s_axis_tdata <= op.value;
          send_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and drives a randomly stalling ready.
  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        res_t got, exp_r;
        got = '{m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tuser[1], m_axis_tdata[45:32]};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r || m_axis_tdata[47:46] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %p, got %p", exp_r, got);
          end
        end
      end
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  function automatic logic [31:0] pick_value();
    // Keys drawn mostly from a small pool so clusters fill and get reused.
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {23'($urandom_range(0, 2)), 9'($urandom())};
      2: return {23'h7FFFFF - 23'($urandom_range(0, 1)), 9'($urandom())};
      default: return {23'($urandom_range(0, 19) * 1031), 9'($urandom())};
    endcase
  endfunction

  initial begin
    op_t op;
    logic [2:0] c;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    pending_ops.push_back('{scb_pkg::CmdFind, 32'h0});
    pending_ops.push_back('{scb_pkg::CmdAdd, 32'h0});
    pending_ops.push_back('{scb_pkg::CmdAdd, 32'h0});
    pending_ops.push_back('{scb_pkg::CmdAdd, 32'hFFFFFFFF});
    pending_ops.push_back('{scb_pkg::CmdTest, 32'hFFFFFFFF});
    pending_ops.push_back('{scb_pkg::CmdTest, 32'hFFFFFFFE});
    pending_ops.push_back('{scb_pkg::CmdFind, 32'h1});
    pending_ops.push_back('{scb_pkg::CmdFind, 32'hFFFFFFFF});
    pending_ops.push_back('{scb_pkg::CmdRemove, 32'h0});
    pending_ops.push_back('{scb_pkg::CmdRemove, 32'h0});
    pending_ops.push_back('{scb_pkg::CmdRemove, 32'h12345678});
    pending_ops.push_back('{scb_pkg::CmdFind, 32'h0});
    pending_ops.push_back('{3'd5, 32'hAAAAAAAA});
    pending_ops.push_back('{3'd7, 32'h55555555});
    // Seventeen new keys in descending order fill the table; the last three get refused.
    for (int k = 0; k < 17; k++)
      pending_ops.push_back('{scb_pkg::CmdAdd, {23'(40 - 2 * k), 9'(k * 31)}});
    pending_ops.push_back('{scb_pkg::CmdFind, 32'h0});
    pending_ops.push_back('{scb_pkg::CmdClear, 32'h0});
    pending_ops.push_back('{scb_pkg::CmdTest, 32'hFFFFFFFF});

    for (int n = 0; n < 1950; n++) begin
      if (n == 400) begin
        // Hold the receiver off while the sender keeps offering items.
        wait (pending_ops.size() == 0);
        hold_cycles <= 400;
      end
      c = $urandom_range(0, 99) < 40 ? scb_pkg::CmdAdd : 3'($urandom_range(0, 7));
      if (c == scb_pkg::CmdClear && $urandom_range(0, 5) != 0) c = scb_pkg::CmdTest;
      op = '{c, pick_value()};
      pending_ops.push_back(op);
      if (pending_ops.size() > 50) @(posedge clk);
    end
    wait (pending_ops.size() == 0 && !s_axis_tvalid);
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/scb_pkg.sv
rtl/scb_ram.sv
rtl/sparse_clustered_bitset.sv
tb/tb_sparse_clustered_bitset.sv
